// ===== rtl/seoc_pkg.sv =====
// Shared types and constants for the entropy-of-counts block.
`timescale 1ns / 1ps
`default_nettype none
package seoc_pkg;

  localparam int FREQ_W    = 24;
  localparam int ENTROPY_W = 22;
  localparam int TOTOUT_W  = 32;
  localparam int ENTRY_W   = 32;
  localparam int SUM_W     = 54;
  localparam int DIVCNT_W  = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOG,
    ST_MUL,
    ST_ACC,
    ST_TLOG,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic log_freq;
    logic mul;
    logic acc;
    logic log_total;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/seoc_if.sv =====
// Valid/ready channel interfaces for counts in and results out.
`timescale 1ns / 1ps
`default_nettype none
interface seoc_in_if;
  import seoc_pkg::*;
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency;
  logic              last;
  modport source (output valid, frequency, last, input ready);
  modport sink (input valid, frequency, last, output ready);
endinterface

interface seoc_out_if;
  import seoc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ENTROPY_W-1:0] entropy;
  logic [TOTOUT_W-1:0]  total;
  logic [ENTRY_W-1:0]   entries;
  logic                 overflow;
  modport source (output valid, entropy, total, entries, overflow, input ready);
  modport sink (input valid, entropy, total, entries, overflow, output ready);
endinterface
`default_nettype wire

// ===== rtl/seoc_ctrl.sv =====
// Sequencing state machine for the entropy-of-counts block.
`timescale 1ns / 1ps
`default_nettype none
module seoc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  seoc_pkg::status_t  status,
  output seoc_pkg::cmd_t     cmd
);
  import seoc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOG;
        end
      end
      ST_LOG: begin
        cmd.log_freq = 1'b1;
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? ST_TLOG : ST_IDLE;
      end
      ST_TLOG: begin
        cmd.log_total = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/seoc_dp.sv =====
// Datapath: log2 unit, multiply-accumulate, serial divider and result register.
`timescale 1ns / 1ps
`default_nettype none
module seoc_dp #(
  parameter int COUNT_BITS     = 24,
  parameter int TOTAL_BITS     = 32,
  parameter int FRAC_BITS      = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [seoc_pkg::FREQ_W-1:0]       frequency,
  input  logic                              last,
  input  seoc_pkg::cmd_t                    cmd,
  output seoc_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [seoc_pkg::ENTROPY_W-1:0]    entropy,
  output logic [seoc_pkg::TOTOUT_W-1:0]     total,
  output logic [seoc_pkg::ENTRY_W-1:0]      entries,
  output logic                              overflow
);
  import seoc_pkg::*;

  localparam int LW     = (COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS;
  localparam int EXP_W  = $clog2(LW);
  localparam int LOG_W  = EXP_W + FRAC_BITS;
  localparam int PW     = COUNT_BITS + LOG_W;
  localparam int AW     = ((PW > SUM_W) ? PW : SUM_W) + 1;
  localparam int ROM_N  = 2 ** LOG_TABLE_BITS;
  localparam int MANT_F = 30;
  localparam int WIDE_W = 64;

  function automatic logic [FRAC_BITS-1:0] rom_fraction(input int idx);
    logic [63:0] m;
    logic [FRAC_BITS-1:0] r;
    m = (64'(ROM_N) + 64'(idx)) << (MANT_F - LOG_TABLE_BITS);
    r = '0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      m = (m * m) >> MANT_F;
      r = r << 1;
      if (m >= (64'd2 << MANT_F)) begin
        m = m >> 1;
        r[0] = 1'b1;
      end
    end
    return r;
  endfunction

  logic [FRAC_BITS-1:0] rom [ROM_N];
  for (genvar g = 0; g < ROM_N; g++) begin : g_rom
    assign rom[g] = rom_fraction(g);
  end

  // item registers
  logic [COUNT_BITS-1:0] f_in, freq;
  logic                  last_q;
  if (COUNT_BITS <= FREQ_W) begin : g_fnarrow
    assign f_in = frequency[COUNT_BITS-1:0];
  end else begin : g_fwide
    assign f_in = COUNT_BITS'(frequency);
  end

  logic [TOTAL_BITS-1:0] tot;
  logic [SUM_W-1:0]      sum;
  logic [ENTRY_W-1:0]    cnt;
  logic                  sat;
  logic [LOG_W-1:0]      lf, lt;
  logic [PW-1:0]         prod;

  // shared log2 unit
  logic [LW-1:0]             log_x;
  logic [EXP_W-1:0]          log_e;
  logic [LOG_TABLE_BITS-1:0] log_idx;
  logic [LOG_W-1:0]          log_y;

  assign log_x = cmd.log_total ? LW'(tot) : LW'(freq);

  always_comb begin
    log_e = '0;
    for (int i = 0; i < LW; i++) begin
      if (log_x[i]) log_e = EXP_W'(i);
    end
    if (int'(log_e) >= LOG_TABLE_BITS) begin
      log_idx = LOG_TABLE_BITS'(log_x >> (int'(log_e) - LOG_TABLE_BITS));
    end else begin
      log_idx = LOG_TABLE_BITS'(log_x << (LOG_TABLE_BITS - int'(log_e)));
    end
    log_y = {log_e, rom[log_idx]};
  end

  // saturating accumulation
  logic [AW-1:0]         sum_add;
  logic [LW:0]           tot_add;
  logic                  sum_ovf, tot_ovf;
  assign sum_add = AW'(sum) + AW'(prod);
  assign tot_add = (LW+1)'(tot) + (LW+1)'(freq);
  assign sum_ovf = sum_add > AW'({SUM_W{1'b1}});
  assign tot_ovf = tot_add > (LW+1)'({TOTAL_BITS{1'b1}});

  // restoring divider
  logic [TOTAL_BITS:0]   rem, rem_sh;
  logic [SUM_W-1:0]      quo;
  logic [DIVCNT_W-1:0]   dcnt;
  logic                  ge;
  assign rem_sh = {rem[TOTAL_BITS-1:0], quo[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, tot};

  logic [SUM_W-1:0]      h;
  logic [SUM_W-1:0]      lt_ext;
  assign lt_ext = SUM_W'(lt);
  always_comb begin
    h = (lt_ext > quo) ? lt_ext - quo : '0;
    if (h > SUM_W'((1 << ENTROPY_W) - 1)) h = SUM_W'((1 << ENTROPY_W) - 1);
  end

  assign status.last     = last_q;
  assign status.div_done = dcnt == DIVCNT_W'(SUM_W - 1);
  assign status.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      freq   <= f_in;
      last_q <= last;
    end
    if (cmd.log_freq) lf <= log_y;
    if (cmd.mul) prod <= PW'(freq) * PW'(lf);
    if (cmd.log_total) begin
      lt   <= log_y;
      rem  <= '0;
      quo  <= sum;
    end
    if (cmd.div_step) begin
      rem <= ge ? rem_sh - {1'b0, tot} : rem_sh;
      quo <= {quo[SUM_W-2:0], ge};
    end
    if (cmd.emit) begin
      entropy  <= h[ENTROPY_W-1:0];
      total    <= TOTOUT_W'(WIDE_W'(tot));
      entries  <= cnt;
      overflow <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tot       <= '0;
      sum       <= '0;
      cnt       <= '0;
      sat       <= 1'b0;
      dcnt      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.acc) begin
        if (sum_ovf) begin
          sum <= '1;
        end else begin
          sum <= sum_add[SUM_W-1:0];
        end
        if (tot_ovf) begin
          tot <= '1;
        end else begin
          tot <= tot_add[TOTAL_BITS-1:0];
        end
        if (sum_ovf || tot_ovf) sat <= 1'b1;
        if (cnt != '1) cnt <= cnt + ENTRY_W'(1);
      end
      if (cmd.log_total) dcnt <= '0;
      else if (cmd.div_step) dcnt <= dcnt + DIVCNT_W'(1);
      if (cmd.emit) begin
        out_valid <= 1'b1;
        tot       <= '0;
        sum       <= '0;
        cnt       <= '0;
        sat       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/shannon_entropy_of_counts_core.sv =====
// Top level of the entropy-of-counts block: controller plus datapath.
// Usage: counts arrive on the counts channel, one frequency per transfer,
// with last closing a group. Each group yields one transfer on the result
// channel: entropy in unsigned Q.16 bits, saturated total, number of
// counts and an overflow flag.
// Sequence: a count not flagged last passes through accept, log2 table
// lookup, multiply and saturating accumulate. A last count then adds log2
// of the total, the one-bit-per-cycle restoring divider for S/T, and the
// load of the result register.
// The result register sits apart from the working state, so the next
// group's counts are taken while a result waits; only the load of the
// following result waits for the receiver to take the current one.
// Reset (rst, synchronous) clears the group state and drops result valid.
`timescale 1ns / 1ps
`default_nettype none
module shannon_entropy_of_counts_core #(
  parameter int COUNT_BITS     = 24,
  parameter int TOTAL_BITS     = 32,
  parameter int FRAC_BITS      = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic       clk,
  input  logic       rst,
  seoc_in_if.sink    counts,
  seoc_out_if.source result
);
  import seoc_pkg::*;

  cmd_t    cmd;
  status_t status;

  seoc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (counts.valid),
    .in_ready (counts.ready),
    .status   (status),
    .cmd      (cmd)
  );

  seoc_dp #(
    .COUNT_BITS     (COUNT_BITS),
    .TOTAL_BITS     (TOTAL_BITS),
    .FRAC_BITS      (FRAC_BITS),
    .LOG_TABLE_BITS (LOG_TABLE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .frequency (counts.frequency),
    .last      (counts.last),
    .cmd       (cmd),
    .status    (status),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .entropy   (result.entropy),
    .total     (result.total),
    .entries   (result.entries),
    .overflow  (result.overflow)
  );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the entropy-of-counts block: directed and random count groups checked.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import seoc_pkg::*;

  localparam int  CNT_BITS   = 24;
  localparam int  TOT_BITS   = 32;
  localparam int  FRAC       = 16;
  localparam int  LUT_BITS   = 8;
  localparam int  MANT       = 30;
  localparam longint unsigned SUM_SAT   = (64'd1 << 54) - 1;
  localparam longint unsigned TOT_SAT   = (64'd1 << TOT_BITS) - 1;
  localparam longint unsigned H_MAX     = (64'd1 << ENTROPY_W) - 1;
  localparam int  CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [FREQ_W-1:0] freq;
    logic              last;
    bit                drain_first;
  } count_t;

  typedef struct {
    logic [ENTROPY_W-1:0] entropy;
    logic [TOTOUT_W-1:0]  total;
    logic [ENTRY_W-1:0]   entries;
    logic                 overflow;
  } group_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  seoc_in_if  cin ();
  seoc_out_if rout ();

  shannon_entropy_of_counts_core dut (.clk(clk), .rst(rst), .counts(cin), .result(rout));

  count_t     pending_counts[$];
  group_res_t group_results[$];
  int         errors = 0;
  int         results_seen = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;

  // running group state
  longint unsigned grp_total, grp_sum;
  logic [31:0]     grp_entries;
  bit              grp_sat;

  function automatic longint unsigned log_frac(longint unsigned idx);
    longint unsigned m, r;
    m = ((64'd1 << LUT_BITS) + idx) << (MANT - LUT_BITS);
    r = 0;
    for (int k = 0; k < FRAC; k++) begin
      m = (m * m) >> MANT;
      r = r << 1;
      if (m >= (64'd2 << MANT)) begin
        m = m >> 1;
        r = r | 64'd1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q(longint unsigned x);
    longint unsigned idx;
    int e;
    e = 0;
    if (x == 0) return 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    if (e >= LUT_BITS) idx = (x >> (e - LUT_BITS)) & ((64'd1 << LUT_BITS) - 1);
    else idx = (x << (LUT_BITS - e)) & ((64'd1 << LUT_BITS) - 1);
    return (longint'(e) << FRAC) + log_frac(idx);
  endfunction

  task automatic accumulate_count(count_t c);
    longint unsigned f, prod, lt, q, h;
    group_res_t r;
    f = c.freq & ((64'd1 << CNT_BITS) - 1);
    if (f != 0) begin
      prod = f * log2_q(f);
      if (prod > SUM_SAT - grp_sum) begin
        grp_sum = SUM_SAT;
        grp_sat = 1'b1;
      end else grp_sum += prod;
      if (f > TOT_SAT - grp_total) begin
        grp_total = TOT_SAT;
        grp_sat = 1'b1;
      end else grp_total += f;
    end
    if (grp_entries != 32'hFFFF_FFFF) grp_entries++;
    if (c.last) begin
      h = 0;
      if (grp_total != 0) begin
        lt = log2_q(grp_total);
        q = grp_sum / grp_total;
        h = (lt > q) ? lt - q : 0;
        if (h > H_MAX) h = H_MAX;
      end
      r.entropy  = h[ENTROPY_W-1:0];
      r.total    = grp_total[TOTOUT_W-1:0];
      r.entries  = grp_entries;
      r.overflow = grp_sat;
      group_results.insert(group_results.size(), r);
      grp_total = 0; grp_sum = 0; grp_entries = 0; grp_sat = 1'b0;
    end
  endtask

  task automatic report(string what, longint unsigned got, longint unsigned want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  task automatic add_count(longint unsigned f, bit l, bit drain = 1'b0);
    count_t c;
    c.freq = f[FREQ_W-1:0];
    c.last = l;
    c.drain_first = drain;
    pending_counts.insert(pending_counts.size(), c);
  endtask

  // driver
  count_t cur;
  int     src_gap = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      cin.valid <= 1'b0;
    end else begin
      if (cin.valid && cin.ready) accumulate_count(cur);
      if (!cin.valid || cin.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          cin.valid <= 1'b0;
        end else if (pending_counts.size() != 0 &&
                     !(pending_counts[0].drain_first && group_results.size() != 0)) begin
          cur = pending_counts.pop_front();
          cin.valid <= 1'b1;
          cin.frequency <= cur.freq;
          cin.last <= cur.last;
          if (!quiet && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 12);
        end else begin
          cin.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold
  int long_hold = 0;
  bit long_done = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      long_hold <= 0;
      long_done <= 1'b0;
    end else if (!long_done && results_seen >= 20) begin
      long_done <= 1'b1;
      long_hold <= 600;
    end else if (long_hold > 0) begin
      long_hold <= long_hold - 1;
    end
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    group_res_t w;
    if (rst) begin
      rout.ready <= 1'b0;
    end else begin
      if (rout.valid && rout.ready) begin
        if (group_results.size() == 0) begin
          report("unexpected result transfer", 1, 0);
        end else begin
          w = group_results.pop_front();
          if (rout.entropy !== w.entropy) report("entropy", rout.entropy, w.entropy);
          if (rout.total !== w.total) report("total", rout.total, w.total);
          if (rout.entries !== w.entries) report("entries", rout.entries, w.entries);
          if (rout.overflow !== w.overflow) report("overflow", rout.overflow, w.overflow);
        end
        results_seen++;
      end
      if (long_hold > 0) begin
        rout.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        rout.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        sink_gap <= $urandom_range(0, 11);
        rout.ready <= 1'b0;
      end else begin
        rout.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n, w;
    cin.valid = 1'b0;
    cin.frequency = '0;
    cin.last = 1'b0;
    rout.ready = 1'b0;
    grp_total = 0; grp_sum = 0; grp_entries = 0; grp_sat = 1'b0;

    add_count(0, 1);
    add_count(1, 1);
    add_count(24'hFFFFFF, 1);
    add_count(1, 0); add_count(1, 1);
    add_count(0, 0); add_count(0, 0); add_count(5, 1);
    add_count(24'hAAAAAA, 0); add_count(24'h555555, 1);
    add_count(1, 0); add_count(2, 0); add_count(4, 0); add_count(8, 0);
    add_count(24'h800000, 1);
    add_count(3, 0); add_count(1000, 0); add_count(0, 0); add_count(77, 1);
    add_count(24'h000100, 0); add_count(24'h0001FF, 1);
    // total saturation
    for (int i = 0; i < 300; i++) add_count(24'hFFFFFF, i == 299);
    add_count(7, 1, 1'b1);

    for (int i = 0; i < 180; i++) begin
      w = $urandom_range(0, 24);
      n = (w == 0) ? 0 : ($urandom & ((1 << w) - 1));
      add_count(n, $urandom_range(0, 4) == 0, i == 90);
    end
    add_count($urandom_range(0, 255), 1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_counts.size() > 60) @(posedge clk);
    quiet = 1'b1;
    while (pending_counts.size() != 0 || cin.valid) @(posedge clk);
    while (group_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/seoc_pkg.sv
rtl/seoc_if.sv
rtl/seoc_ctrl.sv
rtl/seoc_dp.sv
rtl/shannon_entropy_of_counts_core.sv
dv/tb_top.sv
